[rtl/core/fgts_pkg.sv]
`default_nettype none
package fgts_pkg;

	localparam int MaxElements = 1024;
	localparam int PosBits = 10;
	localparam int CountBits = 11;
	localparam int ValueBits = 32;

	localparam logic [1:0] StatFound = 2'd0;
	localparam logic [1:0] StatNone = 2'd1;
	localparam logic [1:0] StatBadIndex = 2'd2;

	localparam logic KindWrite = 1'b0;
	localparam logic KindQuery = 1'b1;

	typedef struct packed {
		logic kind;
		logic [PosBits-1:0] first_index;
		logic [PosBits-1:0] second_index;
		logic [ValueBits-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [PosBits-1:0] position;
	} rsp_t;

	// classified command from the front part
	typedef struct packed {
		logic is_query;
		logic bad;
		logic [PosBits-1:0] lo;
		logic [PosBits-1:0] hi;
		logic [CountBits-1:0] cnt;
		logic [ValueBits-1:0] value;
	} cmd_t;

	typedef enum logic [2:0] {
		BkClear,
		BkIdle,
		BkRdLo,
		BkRdHi,
		BkCmp,
		BkScanRd,
		BkScanCmp,
		BkOut
	} bk_state_t;

endpackage
`default_nettype wire

[rtl/core/fgts_front.sv]
`default_nettype none
module fgts_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire fgts_pkg::req_t in_data,
	input  wire logic [fgts_pkg::CountBits-1:0] count,
	output logic cmd_valid,
	input  wire logic cmd_ready,
	output fgts_pkg::cmd_t cmd_data
);
	// two-entry queue
	fgts_pkg::cmd_t buf_q [2];
	logic wptr_q, rptr_q;
	logic [1:0] fill_q;
	fgts_pkg::cmd_t c;
	logic [fgts_pkg::CountBits-1:0] eff;
	logic push, pop;

	always_comb begin
		eff = (count > fgts_pkg::CountBits'(fgts_pkg::MaxElements)) ?
			fgts_pkg::CountBits'(fgts_pkg::MaxElements) : count;
		c.is_query = (in_data.kind == fgts_pkg::KindQuery);
		c.cnt = eff;
		c.value = in_data.value;
		c.bad = ({1'b0, in_data.first_index} >= eff) || ({1'b0, in_data.second_index} >= eff);
		if (!c.is_query) begin
			c.lo = in_data.first_index;
			c.hi = in_data.first_index;
		end else if (in_data.first_index < in_data.second_index) begin
			c.lo = in_data.first_index;
			c.hi = in_data.second_index;
		end else begin
			c.lo = in_data.second_index;
			c.hi = in_data.first_index;
		end
	end

	assign in_ready = (fill_q != 2'd2);
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd_data = buf_q[rptr_q];
	assign push = in_valid && in_ready;
	assign pop = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) buf_q[wptr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop) rptr_q <= !rptr_q;
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

[rtl/core/fgts_back.sv]
`default_nettype none
module fgts_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic cmd_ready,
	input  wire fgts_pkg::cmd_t cmd_data,
	output logic out_valid,
	input  wire logic out_ready,
	output fgts_pkg::rsp_t out_data
);
	logic [fgts_pkg::ValueBits-1:0] mem [fgts_pkg::MaxElements];
	logic [fgts_pkg::ValueBits-1:0] rd_q, vlo_q, vhi_q;
	logic [fgts_pkg::PosBits-1:0] clr_q;
	logic [fgts_pkg::PosBits-1:0] raddr;
	logic rd_en;
	fgts_pkg::bk_state_t st_q, st_d;
	fgts_pkg::cmd_t cmd_q;
	logic [fgts_pkg::CountBits-1:0] p_q, p_d;
	fgts_pkg::rsp_t res_q, res_d;
	logic take, ld_cmd, ld_lo, ld_hi;
	logic [fgts_pkg::ValueBits-1:0] rval, thr;

	assign take = cmd_valid && cmd_ready;
	assign rval = rd_q;
	assign thr = (vlo_q > vhi_q) ? vlo_q : vhi_q;

	always_ff @(posedge clk) begin
		// clearing pass after reset, then request writes
		if (st_q == fgts_pkg::BkClear) mem[clr_q] <= '0;
		else if (take && !cmd_data.is_query) mem[cmd_data.lo] <= cmd_data.value;
		if (rd_en) rd_q <= mem[raddr];
		if (ld_cmd) cmd_q <= cmd_data;
		if (ld_lo) vlo_q <= rval;
		if (ld_hi) vhi_q <= rval;
		p_q <= p_d;
		res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= fgts_pkg::BkClear;
			clr_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == fgts_pkg::BkClear) clr_q <= clr_q + 1'b1;
		end
	end

	// sequencer: read lo, read hi, then scan right one position at a time, a read state then a compare state each
	always_comb begin
		st_d = st_q;
		p_d = p_q;
		res_d = res_q;
		cmd_ready = 1'b0;
		rd_en = 1'b0;
		raddr = cmd_q.lo;
		ld_cmd = 1'b0;
		ld_lo = 1'b0;
		ld_hi = 1'b0;
		out_valid = 1'b0;
		unique case (st_q)
			fgts_pkg::BkClear: begin
				if (clr_q == '1) st_d = fgts_pkg::BkIdle;
			end
			fgts_pkg::BkIdle: begin
				cmd_ready = 1'b1;
				if (cmd_valid && cmd_data.is_query) begin
					ld_cmd = 1'b1;
					if (cmd_data.bad) begin
						res_d = '{fgts_pkg::StatBadIndex, '0};
						st_d = fgts_pkg::BkOut;
					end else if (cmd_data.lo == cmd_data.hi) begin
						res_d = '{fgts_pkg::StatFound, cmd_data.lo};
						st_d = fgts_pkg::BkOut;
					end else begin
						st_d = fgts_pkg::BkRdLo;
					end
				end
			end
			fgts_pkg::BkRdLo: begin
				rd_en = 1'b1;
				raddr = cmd_q.lo;
				st_d = fgts_pkg::BkRdHi;
			end
			fgts_pkg::BkRdHi: begin
				rd_en = 1'b1;
				raddr = cmd_q.hi;
				ld_lo = 1'b1;
				st_d = fgts_pkg::BkCmp;
			end
			fgts_pkg::BkCmp: begin
				ld_hi = 1'b1;
				if (rval > vlo_q) begin
					res_d = '{fgts_pkg::StatFound, cmd_q.hi};
					st_d = fgts_pkg::BkOut;
				end else begin
					p_d = {1'b0, cmd_q.hi} + 1'b1;
					st_d = fgts_pkg::BkScanRd;
				end
			end
			fgts_pkg::BkScanRd: begin
				if (p_q >= cmd_q.cnt) begin
					res_d = '{fgts_pkg::StatNone, '0};
					st_d = fgts_pkg::BkOut;
				end else begin
					rd_en = 1'b1;
					raddr = p_q[fgts_pkg::PosBits-1:0];
					st_d = fgts_pkg::BkScanCmp;
				end
			end
			fgts_pkg::BkScanCmp: begin
				if (rval > thr) begin
					res_d = '{fgts_pkg::StatFound, p_q[fgts_pkg::PosBits-1:0]};
					st_d = fgts_pkg::BkOut;
				end else begin
					p_d = p_q + 1'b1;
					st_d = fgts_pkg::BkScanRd;
				end
			end
			fgts_pkg::BkOut: begin
				out_valid = 1'b1;
				if (out_ready) st_d = fgts_pkg::BkIdle;
			end
			default: st_d = fgts_pkg::BkIdle;
		endcase
	end

	assign out_data = res_q;
endmodule
`default_nettype wire

[rtl/core/first_greater_to_right_search_core.sv]
`default_nettype none
// first-greater-to-the-right search over a 1024-entry store of 32-bit values.
// a write request stores one value (written as the back end takes it, no response).
// a query request returns the leftmost position after hi whose value beats both
// named values, hi itself if value[hi] > value[lo], lo if a equals b, or a
// none / bad-index status. a bad index or a equal to b is answered straight from
// the idle state; otherwise the back end reads lo, then hi, and answers if hi
// wins, else walks the value memory rightwards from hi one position at a time
// through its single read port until a value beats both or count is reached.
// the request queue registers each request in front of the back end, and the
// back end takes its next request in the cycle after the response is accepted.
// a two-entry request queue lets the front accept while the back end works.
// after reset the back end clears all 1024 entries of the store and takes no
// requests meanwhile, so the store reads as zero.
// the element count is taken per request when it enters the queue.
module first_greater_to_right_search_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire fgts_pkg::req_t in_data,
	output logic out_valid,
	input  wire logic out_ready,
	output fgts_pkg::rsp_t out_data,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [fgts_pkg::CountBits-1:0] cfg_data
);
	logic [fgts_pkg::CountBits-1:0] count_q;
	logic cmd_valid, cmd_ready;
	fgts_pkg::cmd_t cmd_data;

	// config register, always writable
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= fgts_pkg::CountBits'(1);
		else if (cfg_valid) count_q <= cfg_data;
	end

	fgts_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.count(count_q),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data)
	);

	fgts_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule
`default_nettype wire

[rtl/core/fgts_checker.sv]
`default_nettype none
module fgts_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire fgts_pkg::rsp_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("response dropped while stalled");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status <= fgts_pkg::StatBadIndex))
		else $error("bad status code");
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != fgts_pkg::StatFound |-> out_data.position == '0)
		else $error("position set without found status");
endmodule

bind first_greater_to_right_search_core fgts_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid),
	.out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
`default_nettype none
module testbench;

	localparam int CycleLimit = 20000000;
	localparam int SettleCycles = 60;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	fgts_pkg::req_t in_data;
	logic out_valid;
	logic out_ready;
	fgts_pkg::rsp_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [fgts_pkg::CountBits-1:0] cfg_data;

	first_greater_to_right_search_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// free-running clock, 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow copy of the block state, kept in request acceptance order
	logic [fgts_pkg::ValueBits-1:0] shadow_values [fgts_pkg::MaxElements];
	logic [fgts_pkg::CountBits-1:0] shadow_count;
	fgts_pkg::rsp_t answer_q[$];

	int errors = 0;
	int cycles = 0;
	int n_requests = 0;
	int n_answers = 0;
	int n_writes = 0;
	// calm turns off random idling on both sides
	bit calm = 0;
	int hold_req = 0;

	// expected answer for one request; writes update the shadow store instead
	function automatic bit predict_answer(input fgts_pkg::req_t r, output fgts_pkg::rsp_t ans);
		int cnt;
		int lo;
		int hi;
		bit have;
		ans = '0;
		if (r.kind == fgts_pkg::KindWrite) begin
			shadow_values[r.first_index] = r.value;
			return 0;
		end
		cnt = (shadow_count > fgts_pkg::MaxElements) ? fgts_pkg::MaxElements : shadow_count;
		if (r.first_index >= cnt || r.second_index >= cnt) begin
			ans.status = fgts_pkg::StatBadIndex;
			return 1;
		end
		lo = (r.first_index < r.second_index) ? r.first_index : r.second_index;
		hi = (r.first_index < r.second_index) ? r.second_index : r.first_index;
		if (lo == hi) begin
			ans.status = fgts_pkg::StatFound;
			ans.position = fgts_pkg::PosBits'(lo);
			return 1;
		end
		if (shadow_values[hi] > shadow_values[lo]) begin
			ans.status = fgts_pkg::StatFound;
			ans.position = fgts_pkg::PosBits'(hi);
			return 1;
		end
		// value[lo] >= value[hi], so beating lo beats both
		have = 0;
		for (int p = hi + 1; p < cnt && !have; p++) begin
			if (shadow_values[p] > shadow_values[lo]) begin
				have = 1;
				ans.position = fgts_pkg::PosBits'(p);
			end
		end
		ans.status = have ? fgts_pkg::StatFound : fgts_pkg::StatNone;
		return 1;
	endfunction

	// hands one request to the block; valid is left high for a back-to-back follower
	task automatic send_request(input fgts_pkg::req_t r);
		fgts_pkg::rsp_t ans;
		while (!calm && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
		n_requests++;
		if (predict_answer(r, ans))
			answer_q = {answer_q, ans};
		else
			n_writes++;
	endtask

	task automatic send_write(input int pos, input logic [31:0] val);
		fgts_pkg::req_t r;
		r.kind = fgts_pkg::KindWrite;
		r.first_index = fgts_pkg::PosBits'(pos);
		r.second_index = fgts_pkg::PosBits'($urandom);
		r.value = val;
		send_request(r);
	endtask

	task automatic send_query(input int a, input int b);
		fgts_pkg::req_t r;
		r.kind = fgts_pkg::KindQuery;
		r.first_index = fgts_pkg::PosBits'(a);
		r.second_index = fgts_pkg::PosBits'(b);
		r.value = $urandom;
		send_request(r);
	endtask

	// sender pause until every answer is back, plus time for trailing writes
	task automatic drain;
		in_valid <= 1'b0;
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// count register is only changed with the block idle
	task automatic set_count(input int cnt);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= fgts_pkg::CountBits'(cnt);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_count = fgts_pkg::CountBits'(cnt);
		@(posedge clk);
	endtask

	// receiver: random stalls, long hold-off on request, checks every answer
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (answer_q.size() == 0) begin
					$error("unexpected answer status=%0d position=%0d",
						out_data.status, out_data.position);
					errors++;
				end else begin
					fgts_pkg::rsp_t e;
					e = answer_q.pop_front();
					n_answers++;
					if (out_data.status !== e.status) begin
						$error("status: expected %0d, actual %0d", e.status, out_data.status);
						errors++;
					end
					if (out_data.position !== e.position) begin
						$error("position: expected %0d, actual %0d",
							e.position, out_data.position);
						errors++;
					end
				end
			end
			if (hold_req > 0) begin
				out_ready <= 1'b0;
				hold_req <= hold_req - 1;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 29);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	// extremes of count, values and indices, and every query outcome
	task automatic test_directed;
		send_query(0, 0);           // reset count of one: found at lo
		send_query(0, 1);           // beyond count
		set_count(0);
		send_query(0, 0);           // count zero: everything is a bad index
		set_count(8);
		send_write(0, 32'd5);
		send_write(1, 32'd3);
		send_write(2, 32'd9);
		send_write(3, 32'hFFFF_FFFF);
		send_write(7, 32'd0);
		send_query(1, 0);           // scan: first beating 5 after 1 is 2
		send_query(0, 2);           // hi wins
		send_query(3, 5);           // nothing beats the max
		send_query(6, 7);           // hi is last position in use
		send_query(4, 4);
		send_query(1023, 0);        // far out of range
		send_write(20, 32'd77);     // stored but not yet visible
		send_query(5, 6);
		set_count(2047);            // above capacity acts as full size
		send_query(5, 6);           // now sees position 20
		send_query(1023, 1023);
		send_query(1022, 1023);
		send_write(1023, 32'd1);
		send_query(1022, 1021);     // leftmost beating 0 is 1023
	endtask

	task automatic test_random(input int cnt, input int n, input bit wide_values);
		int span;
		set_count(cnt);
		span = (cnt > fgts_pkg::MaxElements) ? fgts_pkg::MaxElements : cnt;
		if (span < 1)
			span = 1;
		for (int i = 0; i < n; i++) begin
			int pick;
			logic [31:0] v;
			pick = $urandom_range(99);
			v = wide_values ? $urandom : $urandom_range(7);
			if (pick < 40)
				send_write($urandom_range(span - 1), v);
			else if (pick < 45)
				send_write($urandom_range(fgts_pkg::MaxElements - 1), $urandom);
			else if (pick < 92)
				send_query($urandom_range(span - 1), $urandom_range(span - 1));
			else
				send_query($urandom_range(fgts_pkg::MaxElements - 1),
					$urandom_range(fgts_pkg::MaxElements - 1));
		end
	endtask

	// receiver holds off while the sender keeps offering requests
	task automatic test_backpressure;
		drain();
		set_count(16);
		hold_req = 400;
		calm = 1;
		for (int i = 0; i < 40; i++)
			send_query($urandom_range(15), $urandom_range(15));
		calm = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		for (int k = 0; k < fgts_pkg::MaxElements; k++)
			shadow_values[k] = '0;
		shadow_count = fgts_pkg::CountBits'(1);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(2, 150, 0);
		test_random(5, 200, 0);
		test_random(16, 250, 1);
		calm = 1;                   // a stretch with no idling anywhere
		test_random(33, 200, 0);
		calm = 0;
		test_backpressure();
		test_random(64, 250, 0);
		test_random(100, 200, 1);
		test_random(3, 150, 0);
		test_random(1, 100, 1);
		test_random(1024, 60, 0);
		test_random(0, 30, 1);
		test_random(2047, 40, 1);
		test_random(12, 100, 0);

		drain();
		$display("covered %0d requests (%0d writes, %0d answers checked) over many counts,",
			n_requests, n_writes, n_answers);
		$display("random stalls on both sides, a long receiver hold-off and full-size scans");
		if (errors == 0 && answer_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("errors %0d, answers still missing %0d", errors, answer_q.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
`default_nettype wire
